// ===== rtl/cptl_pkg.sv =====
// ----------------------------------------------------------------------------
// cptl_pkg
// Shared types, codes and constants of the code point trie lookup block.
// ----------------------------------------------------------------------------
package cptl_pkg;

	localparam int INDEX_DEPTH_DEF = 4096;
	localparam int DATA_DEPTH_DEF  = 16384;

	// full-width address sums, never wrapped
	localparam int IA_W = 17;
	localparam int DA_W = 19;

	localparam int ADDR_W = 4;

	localparam logic [1:0] CMD_LOOKUP   = 2'd0;
	localparam logic [1:0] CMD_WR_INDEX = 2'd1;
	localparam logic [1:0] CMD_WR_DATA  = 2'd2;

	localparam logic [1:0] REG_TOP_POINT  = 2'd0;
	localparam logic [1:0] REG_DEFAULT    = 2'd1;
	localparam logic [1:0] REG_STAGE_BASE = 2'd2;

	localparam logic [20:0] TOP_POINT_RST  = 21'h10FFFF;
	localparam logic [31:0] DEFAULT_RST    = 32'h0;
	localparam logic [11:0] STAGE_BASE_RST = 12'd64;

	localparam logic [20:0] ASCII_LAST = 21'h7F;
	localparam logic [20:0] BMP_LAST   = 21'hFFF;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [20:0] code_point;
		logic [17:0] store_address;
		logic [31:0] store_word;
	} in_word_t;

	typedef struct packed {
		logic [31:0] lookup_value;
		logic        address_fault;
	} out_word_t;

	typedef struct packed {
		logic [20:0] top_point;
		logic [31:0] fallback_value;
		logic [11:0] stage_one_base;
	} cfg_t;

endpackage

// ===== rtl/cptl_regs.sv =====
// ----------------------------------------------------------------------------
// cptl_regs
// APB register file: top code point, fallback value and stage-one base.
// ----------------------------------------------------------------------------
module cptl_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cptl_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	output cptl_pkg::cfg_t                cfg
);
	import cptl_pkg::*;

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.top_point      <= TOP_POINT_RST;
			cfg_q.fallback_value <= DEFAULT_RST;
			cfg_q.stage_one_base <= STAGE_BASE_RST;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_TOP_POINT:  cfg_q.top_point      <= pwdata[20:0];
				REG_DEFAULT:    cfg_q.fallback_value <= pwdata;
				REG_STAGE_BASE: cfg_q.stage_one_base <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_TOP_POINT:  prdata = {11'd0, cfg_q.top_point};
			REG_DEFAULT:    prdata = cfg_q.fallback_value;
			REG_STAGE_BASE: prdata = {20'd0, cfg_q.stage_one_base};
			default:        prdata = 32'd0;
		endcase
	end

endmodule

// ===== rtl/codepoint_trie_lookup.sv =====
// ----------------------------------------------------------------------------
// codepoint_trie_lookup
// Code point trie lookup with writable index and data stores.
// ----------------------------------------------------------------------------
// A lookup is accepted in any cycle, one lookup per cycle sustained, and its
// result appears on done in order and without backpressure. Between accept
// and done lie the chain of three dependent index-store reads, one data-store
// read and the output register. A write is held off (busy) while a lookup
// sits in any of the three stages that read the stores. The index store is
// kept in three identical copies, one per reading stage. Store contents are
// undefined until written.
module codepoint_trie_lookup #(
	parameter int INDEX_DEPTH = cptl_pkg::INDEX_DEPTH_DEF,
	parameter int DATA_DEPTH  = cptl_pkg::DATA_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [cptl_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        start,
	output logic                        busy,
	input  cptl_pkg::in_word_t          item,
	output logic                        done,
	output cptl_pkg::out_word_t         result
);
	import cptl_pkg::*;

	localparam int IW = $clog2(INDEX_DEPTH);
	localparam int DW = $clog2(DATA_DEPTH);

	typedef enum logic [1:0] {
		PATH_ASCII,
		PATH_BMP,
		PATH_SUPP,
		PATH_DEFAULT
	} path_t;

	typedef struct packed {
		path_t       path;
		logic        fault;
		logic [20:0] cp;
	} meta_t;

	cfg_t cfg;

	cptl_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	logic [15:0] idx0_mem [INDEX_DEPTH];
	logic [15:0] idx1_mem [INDEX_DEPTH];
	logic [15:0] idx2_mem [INDEX_DEPTH];
	logic [31:0] data_mem [DATA_DEPTH];

	logic accept, lookup_acc, wr_idx, wr_data;
	logic v_s1, v_s2, v_s3, v_s4;
	meta_t meta_s1, meta_s2, meta_s3;
	logic [15:0] r1_s1, r2_s2, wa_s3, wb_s3;
	logic [DA_W-1:0] da_s2, da_s3;
	logic pk_s3;
	logic fault_s4, dflt_s4;
	logic [31:0] dv_s4;
	logic done_q;
	out_word_t result_q;

	assign busy = (v_s1 || v_s2 || v_s3) &&
		(item.cmd == CMD_WR_INDEX || item.cmd == CMD_WR_DATA);
	assign accept     = start && !busy;
	assign lookup_acc = accept && item.cmd == CMD_LOOKUP;
	assign wr_idx     = accept && item.cmd == CMD_WR_INDEX &&
		32'(item.store_address) < 32'(INDEX_DEPTH);
	assign wr_data    = accept && item.cmd == CMD_WR_DATA &&
		32'(item.store_address) < 32'(DATA_DEPTH);

	always_ff @(posedge clk) begin
		if (wr_idx) begin
			idx0_mem[item.store_address[IW-1:0]] <= item.store_word[15:0];
			idx1_mem[item.store_address[IW-1:0]] <= item.store_word[15:0];
			idx2_mem[item.store_address[IW-1:0]] <= item.store_word[15:0];
		end
		if (wr_data) begin
			data_mem[item.store_address[DW-1:0]] <= item.store_word;
		end
	end

	// stage 0: classify, first index address
	path_t path0;
	logic [IA_W-1:0] a1;
	logic fault0;

	always_comb begin
		a1 = '0;
		if (item.code_point <= ASCII_LAST) begin
			path0 = PATH_ASCII;
		end else if (item.code_point <= BMP_LAST) begin
			path0 = PATH_BMP;
			a1    = IA_W'(item.code_point[11:6]);
		end else if (item.code_point > cfg.top_point) begin
			path0 = PATH_DEFAULT;
		end else begin
			path0 = PATH_SUPP;
			a1    = IA_W'(cfg.stage_one_base) + IA_W'(item.code_point[20:14]);
		end
		fault0 = (path0 == PATH_BMP || path0 == PATH_SUPP) &&
			!(32'(a1) < 32'(INDEX_DEPTH));
	end

	// stage 1: second index address or data address of the short paths
	logic [IA_W-1:0] a2;
	logic [DA_W-1:0] da1;
	logic fault1;

	always_comb begin
		a2  = IA_W'(r1_s1) + IA_W'(meta_s1.cp[13:9]);
		da1 = '0;
		if (meta_s1.path == PATH_ASCII) begin
			da1 = DA_W'(meta_s1.cp[6:0]);
		end else if (meta_s1.path == PATH_BMP) begin
			da1 = DA_W'(r1_s1) + DA_W'(meta_s1.cp[5:0]);
		end
		fault1 = meta_s1.fault ||
			(meta_s1.path == PATH_SUPP && !(32'(a2) < 32'(INDEX_DEPTH)));
	end

	// stage 2: third-level block, plain or packed 18-bit entries
	logic [4:0] i3;
	logic packed2;
	logic [IA_W-1:0] a3a, a3b;
	logic fault2;

	always_comb begin
		i3      = meta_s2.cp[8:4];
		packed2 = r2_s2[15];
		if (!packed2) begin
			a3a = IA_W'(r2_s2) + IA_W'(i3);
			a3b = a3a;
		end else begin
			a3a = IA_W'(r2_s2[14:0]) + IA_W'({i3[4:3], 3'b000}) + IA_W'(i3[4:3]);
			a3b = a3a + IA_W'(1) + IA_W'(i3[2:0]);
		end
		fault2 = meta_s2.fault || (meta_s2.path == PATH_SUPP &&
			(!(32'(a3a) < 32'(INDEX_DEPTH)) ||
			(packed2 && !(32'(a3b) < 32'(INDEX_DEPTH)))));
	end

	// stage 3: data block and final data address
	logic [2:0] k3;
	logic [1:0] hi3;
	logic [17:0] dblk;
	logic [DA_W-1:0] da3;
	logic fault3;

	always_comb begin
		k3   = meta_s3.cp[6:4];
		hi3  = wa_s3[4'(4'd15 - {k3, 1'b0}) -: 2];
		dblk = pk_s3 ? {hi3, wb_s3} : {2'b00, wa_s3};
		if (meta_s3.path == PATH_SUPP) begin
			da3 = DA_W'(dblk) + DA_W'(meta_s3.cp[3:0]);
		end else begin
			da3 = da_s3;
		end
		fault3 = meta_s3.fault || (meta_s3.path != PATH_DEFAULT &&
			!(32'(da3) < 32'(DATA_DEPTH)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= lookup_acc;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			done_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		meta_s1 <= '{path: path0, fault: fault0, cp: item.code_point};
		r1_s1   <= idx0_mem[a1[IW-1:0]];

		meta_s2 <= '{path: meta_s1.path, fault: fault1, cp: meta_s1.cp};
		r2_s2   <= idx1_mem[a2[IW-1:0]];
		da_s2   <= da1;

		meta_s3 <= '{path: meta_s2.path, fault: fault2, cp: meta_s2.cp};
		wa_s3   <= idx2_mem[a3a[IW-1:0]];
		wb_s3   <= idx2_mem[a3b[IW-1:0]];
		pk_s3   <= packed2;
		da_s3   <= da_s2;

		fault_s4 <= fault3;
		dflt_s4  <= meta_s3.path == PATH_DEFAULT;
		dv_s4    <= data_mem[da3[DW-1:0]];

		result_q.lookup_value  <= (fault_s4 || dflt_s4) ? cfg.fallback_value : dv_s4;
		result_q.address_fault <= fault_s4;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== rtl/cptl_checker.sv =====
// ----------------------------------------------------------------------------
// cptl_checker
// Port-level checks of the code point trie lookup, bound to the top level.
// ----------------------------------------------------------------------------
module cptl_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input cptl_pkg::in_word_t  item,
	input logic                done,
	input cptl_pkg::out_word_t result
);
	import cptl_pkg::*;

	logic lookup_acc, write_acc;

	assign lookup_acc = arst_n && start && !busy && item.cmd == CMD_LOOKUP;
	assign write_acc  = start && !busy &&
		(item.cmd == CMD_WR_INDEX || item.cmd == CMD_WR_DATA);

	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done == $past(lookup_acc, 5))
		else $error("done does not follow an accepted lookup by five cycles");

	a_busy_write_only: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (item.cmd == CMD_WR_INDEX || item.cmd == CMD_WR_DATA))
		else $error("busy raised against a lookup");

	a_write_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		write_acc |-> (!$past(lookup_acc, 1) && !$past(lookup_acc, 2) &&
			!$past(lookup_acc, 3)))
		else $error("write taken while a lookup reads the stores");

	a_ascii_no_fault: assert property (@(posedge clk) disable iff (!arst_n)
		$past(lookup_acc && item.code_point <= ASCII_LAST, 5) |->
			!result.address_fault)
		else $error("fault reported on a direct lookup");

endmodule

bind codepoint_trie_lookup cptl_checker u_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.item   (item),
	.done   (done),
	.result (result)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for codepoint_trie_lookup. Tries are grown on the fly:
// before each lookup, every store entry on its path that has not been written
// yet is filled with random but mostly in-range content, so that lookups walk
// all levels, plain and packed stage-three blocks, and the fault exits. A
// shadow copy of both stores and the registers predicts each result word,
// which is compared with the oldest pending prediction as it comes out.
// ----------------------------------------------------------------------------
module tb_top;
	import cptl_pkg::*;

	localparam int INDEX_DEPTH = INDEX_DEPTH_DEF;
	localparam int DATA_DEPTH = DATA_DEPTH_DEF;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [20:0] CP_MAX = 21'h10FFFF;
	localparam logic [17:0] ADDR_MAX = 18'h3FFFF;
	localparam int unsigned PACK_FLAG = 32'h8000;
	localparam int unsigned PACK_LOW_MASK = 32'h7FFF;
	localparam int unsigned PACK_HIGH_MASK = 32'h30000;
	localparam int DRAIN_CYCLES = 10;
	localparam int LIMIT = 500000;

	typedef enum logic [2:0] {
		WALK_DONE,
		NEED_BMP_BLOCK,
		NEED_STAGE_ONE,
		NEED_STAGE_TWO,
		NEED_STAGE_THREE,
		NEED_PACK_HIGH,
		NEED_PACK_LOW,
		NEED_DATA
	} walk_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic start;
	logic busy;
	in_word_t item;
	logic done;
	out_word_t result;

	logic [15:0] index_shadow [INDEX_DEPTH];
	logic [31:0] data_shadow [DATA_DEPTH];
	bit index_written [INDEX_DEPTH];
	bit data_written [DATA_DEPTH];
	cfg_t trie_cfg;

	out_word_t expected_lookups [$];
	logic [20:0] mapped_points [$];

	int errors;
	int lookups_checked;
	int faults_seen;
	int stores_written;
	int items_done;
	int settings_used;
	int cycle_count;
	int unsigned burst_left;

	codepoint_trie_lookup #(
		.INDEX_DEPTH(INDEX_DEPTH),
		.DATA_DEPTH(DATA_DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Walk the trie in the shadow stores. Stops at the first unwritten entry
	// on the path and reports which one, or finishes with the predicted word.
	function automatic walk_t trie_walk(input logic [20:0] cp, output logic [31:0] value,
			output logic fault, output int unsigned need_addr);
		int unsigned c, ia, da, blk3, dblk, w, i3;
		c = 32'(cp);
		value = trie_cfg.fallback_value;
		fault = 1'b1;
		need_addr = 0;
		if (cp <= ASCII_LAST) begin
			da = c;
		end else if (cp <= BMP_LAST) begin
			ia = c >> 6;
			if (!index_written[ia]) begin
				need_addr = ia;
				return NEED_BMP_BLOCK;
			end
			da = 32'(index_shadow[ia]) + (c & 63);
		end else if (cp > trie_cfg.top_point) begin
			fault = 1'b0;
			return WALK_DONE;
		end else begin
			ia = 32'(trie_cfg.stage_one_base) + (c >> 14);
			if (ia >= INDEX_DEPTH) return WALK_DONE;
			if (!index_written[ia]) begin
				need_addr = ia;
				return NEED_STAGE_ONE;
			end
			ia = 32'(index_shadow[ia]) + ((c >> 9) & 31);
			if (ia >= INDEX_DEPTH) return WALK_DONE;
			if (!index_written[ia]) begin
				need_addr = ia;
				return NEED_STAGE_TWO;
			end
			blk3 = 32'(index_shadow[ia]);
			i3 = (c >> 4) & 31;
			if ((blk3 & PACK_FLAG) == 0) begin
				ia = blk3 + i3;
				if (ia >= INDEX_DEPTH) return WALK_DONE;
				if (!index_written[ia]) begin
					need_addr = ia;
					return NEED_STAGE_THREE;
				end
				dblk = 32'(index_shadow[ia]);
			end else begin
				// nine words per group of eight: high-bit word, then eight low words
				ia = (blk3 & PACK_LOW_MASK) + 9 * (i3 >> 3);
				if (ia >= INDEX_DEPTH) return WALK_DONE;
				if (!index_written[ia]) begin
					need_addr = ia;
					return NEED_PACK_HIGH;
				end
				w = 32'(index_shadow[ia]);
				dblk = (w << (2 + 2 * (i3 & 7))) & PACK_HIGH_MASK;
				ia = ia + 1 + (i3 & 7);
				if (ia >= INDEX_DEPTH) return WALK_DONE;
				if (!index_written[ia]) begin
					need_addr = ia;
					return NEED_PACK_LOW;
				end
				dblk = dblk | 32'(index_shadow[ia]);
			end
			da = dblk + (c & 15);
		end
		if (da >= DATA_DEPTH) return WALK_DONE;
		if (!data_written[da]) begin
			need_addr = da;
			return NEED_DATA;
		end
		value = data_shadow[da];
		fault = 1'b0;
		return WALK_DONE;
	endfunction

	// Content for a missing entry: mostly in range, now and then out of depth.
	function automatic logic [31:0] pick_entry(input walk_t need);
		int unsigned r;
		logic [31:0] v;
		r = $urandom_range(0, 99);
		v = 0;
		case (need)
			NEED_BMP_BLOCK: begin
				if (r < 90) v = $urandom_range(0, DATA_DEPTH - 64);
				else if (r < 97) v = $urandom_range(DATA_DEPTH - 63, DATA_DEPTH - 1);
				else v = $urandom_range(0, 16'hFFFF);
			end
			NEED_STAGE_ONE: begin
				if (r < 92) v = $urandom_range(0, INDEX_DEPTH - 32);
				else v = $urandom_range(0, 16'hFFFF);
			end
			NEED_STAGE_TWO: begin
				if (r < 55) v = $urandom_range(0, INDEX_DEPTH - 32);
				else if (r < 95) v = PACK_FLAG | $urandom_range(0, INDEX_DEPTH - 36);
				else v = $urandom_range(0, 16'hFFFF);
			end
			NEED_STAGE_THREE, NEED_PACK_LOW: begin
				if (r < 92) v = $urandom_range(0, DATA_DEPTH - 16);
				else v = $urandom_range(0, 16'hFFFF);
			end
			NEED_PACK_HIGH: begin
				for (int k = 0; k < 8; k++)
					v = (v << 2) | (($urandom_range(0, 99) < 65) ? 0 : $urandom_range(1, 3));
			end
			default: begin
				if (r < 5) v = '0;
				else if (r < 10) v = '1;
				else v = $urandom;
			end
		endcase
		return v;
	endfunction

	function automatic in_word_t make_word(input logic [1:0] cmd, input logic [20:0] cp,
			input logic [17:0] addr, input logic [31:0] word);
		in_word_t w;
		w.cmd = cmd;
		w.code_point = cp;
		w.store_address = addr;
		w.store_word = word;
		return w;
	endfunction

	function automatic int unsigned idle_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (burst_left != 0) begin
			burst_left--;
			return 0;
		end
		if (r < 3) begin
			burst_left = $urandom_range(20, 60);
			return 0;
		end
		if (r < 60) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	// Drive one word, hold it until accepted, then update the shadow state.
	task automatic send_word(input in_word_t w);
		int unsigned gap, need_addr;
		logic [31:0] value;
		logic fault;
		out_word_t want;
		gap = idle_gap();
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item <= w;
		do @(posedge clk); while (busy);
		items_done++;
		case (w.cmd)
			CMD_LOOKUP: begin
				void'(trie_walk(w.code_point, value, fault, need_addr));
				want.lookup_value = value;
				want.address_fault = fault;
				expected_lookups.push_back(want);
			end
			CMD_WR_INDEX: begin
				if (w.store_address < INDEX_DEPTH) begin
					index_shadow[w.store_address] = w.store_word[15:0];
					index_written[w.store_address] = 1'b1;
					stores_written++;
				end
			end
			CMD_WR_DATA: begin
				if (w.store_address < DATA_DEPTH) begin
					data_shadow[w.store_address] = w.store_word;
					data_written[w.store_address] = 1'b1;
					stores_written++;
				end
			end
			default: ;
		endcase
	endtask

	// Fill every unwritten entry on the path of cp, then look it up.
	task automatic map_and_lookup(input logic [20:0] cp);
		walk_t need;
		int unsigned addr;
		logic [31:0] value, word;
		logic fault;
		need = trie_walk(cp, value, fault, addr);
		while (need != WALK_DONE) begin
			word = pick_entry(need);
			if (need == NEED_DATA)
				send_word(make_word(CMD_WR_DATA, 21'($urandom_range(0, CP_MAX)),
					18'(addr), word));
			else
				send_word(make_word(CMD_WR_INDEX, 21'($urandom_range(0, CP_MAX)),
					18'(addr), {16'($urandom), word[15:0]}));
			need = trie_walk(cp, value, fault, addr);
		end
		send_word(make_word(CMD_LOOKUP, cp, 18'($urandom_range(0, ADDR_MAX)), $urandom));
		if (cp > BMP_LAST) begin
			mapped_points.push_back(cp);
			if (mapped_points.size() > 64) void'(mapped_points.pop_front());
		end
	endtask

	task automatic quiesce();
		start <= 1'b0;
		while (expected_lookups.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_cycle(input logic [1:0] idx, input logic wr, input logic [31:0] wdata,
			output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic reg_check(input logic [1:0] idx);
		logic [31:0] rd, want;
		string name;
		apb_cycle(idx, 1'b0, '0, rd);
		case (idx)
			REG_TOP_POINT: begin
				want = 32'(trie_cfg.top_point);
				name = "top_point";
			end
			REG_DEFAULT: begin
				want = trie_cfg.fallback_value;
				name = "fallback_value";
			end
			default: begin
				want = 32'(trie_cfg.stage_one_base);
				name = "stage_one_base";
			end
		endcase
		if (rd !== want) begin
			$error("%s: expected %h, actual %h", name, want, rd);
			errors++;
		end
	endtask

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
		logic [31:0] rd;
		apb_cycle(idx, 1'b1, value, rd);
		case (idx)
			REG_TOP_POINT: trie_cfg.top_point = value[20:0];
			REG_DEFAULT: trie_cfg.fallback_value = value;
			default: trie_cfg.stage_one_base = value[11:0];
		endcase
		reg_check(idx);
	endtask

	task automatic set_config(input logic [20:0] top_point, input logic [31:0] fallback_value,
			input logic [11:0] stage_one_base);
		quiesce();
		reg_write(REG_TOP_POINT, 32'(top_point));
		reg_write(REG_DEFAULT, fallback_value);
		reg_write(REG_STAGE_BASE, 32'(stage_one_base));
		settings_used++;
	endtask

	function automatic logic [20:0] choose_code_point();
		int unsigned r;
		logic [20:0] cp;
		r = $urandom_range(0, 99);
		if (r < 15) begin
			cp = 21'($urandom_range(0, ASCII_LAST));
		end else if (r < 35) begin
			cp = 21'($urandom_range(ASCII_LAST + 1, BMP_LAST));
		end else if (r < 70 && mapped_points.size() != 0) begin
			cp = mapped_points[$urandom_range(0, mapped_points.size() - 1)];
			if ($urandom_range(0, 1) != 0) cp = cp ^ 21'($urandom_range(0, 15));
			else cp = cp ^ 21'($urandom_range(0, 511));
			if (cp > CP_MAX) cp = CP_MAX;
		end else if (r < 90) begin
			cp = 21'($urandom_range(BMP_LAST + 1, CP_MAX));
		end else begin
			case ($urandom_range(0, 5))
				0: cp = '0;
				1: cp = 21'(ASCII_LAST + 1);
				2: cp = BMP_LAST;
				3: cp = 21'(BMP_LAST + 1);
				4: cp = trie_cfg.top_point;
				default: cp = (trie_cfg.top_point < CP_MAX) ?
					21'(trie_cfg.top_point + 1) : CP_MAX;
			endcase
		end
		return cp;
	endfunction

	task automatic random_phase(input int count);
		int stop;
		int unsigned r;
		stop = items_done + count;
		while (items_done < stop) begin
			r = $urandom_range(0, 99);
			if (r < 70)
				map_and_lookup(choose_code_point());
			else if (r < 80)
				send_word(make_word(CMD_WR_DATA, 21'($urandom_range(0, CP_MAX)),
					18'($urandom_range(0, DATA_DEPTH - 1)), $urandom));
			else if (r < 88)
				send_word(make_word(CMD_WR_INDEX, 21'($urandom_range(0, CP_MAX)),
					18'($urandom_range(0, INDEX_DEPTH - 1)), $urandom));
			else if (r < 91)
				send_word(make_word(CMD_WR_INDEX, 21'($urandom_range(0, CP_MAX)),
					18'($urandom_range(INDEX_DEPTH, ADDR_MAX)), $urandom));
			else if (r < 94)
				send_word(make_word(CMD_WR_DATA, 21'($urandom_range(0, CP_MAX)),
					18'($urandom_range(DATA_DEPTH, ADDR_MAX)), $urandom));
			else
				send_word(make_word(CMD_UNUSED, 21'($urandom_range(0, CP_MAX)),
					18'($urandom_range(0, ADDR_MAX)), $urandom));
		end
	endtask

	task automatic test_register_reset();
		reg_check(REG_TOP_POINT);
		reg_check(REG_DEFAULT);
		reg_check(REG_STAGE_BASE);
	endtask

	task automatic test_directed_edges();
		map_and_lookup('0);
		map_and_lookup(ASCII_LAST);
		map_and_lookup(21'(ASCII_LAST + 1));
		map_and_lookup(BMP_LAST);
		map_and_lookup(21'(BMP_LAST + 1));
		map_and_lookup(CP_MAX);
		send_word(make_word(CMD_UNUSED, CP_MAX, ADDR_MAX, '1));
		send_word(make_word(CMD_WR_INDEX, CP_MAX, 18'(INDEX_DEPTH), '1));
		send_word(make_word(CMD_WR_DATA, CP_MAX, ADDR_MAX, '1));
	endtask

	task automatic test_random_phases();
		set_config(CP_MAX, '0, STAGE_BASE_RST);
		random_phase(300);
		set_config('0, '1, '0);
		random_phase(200);
		set_config(21'($urandom_range(BMP_LAST + 1, CP_MAX)), $urandom, '1);
		random_phase(200);
		set_config(CP_MAX, $urandom, 12'($urandom_range(0, 12'hFFF)));
		random_phase(250);
		set_config(21'(BMP_LAST + 1), $urandom, 12'($urandom_range(0, 200)));
		random_phase(200);
		set_config(21'($urandom_range(0, CP_MAX)), '0, STAGE_BASE_RST);
		random_phase(200);
	endtask

	// check each result word against the oldest pending lookup
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_lookups.size() == 0) begin
				$error("result word with no lookup pending: %h", result);
				errors++;
			end else begin
				if (result.lookup_value !== expected_lookups[0].lookup_value) begin
					$error("lookup_value: expected %h, actual %h",
						expected_lookups[0].lookup_value, result.lookup_value);
					errors++;
				end
				if (result.address_fault !== expected_lookups[0].address_fault) begin
					$error("address_fault: expected %b, actual %b",
						expected_lookups[0].address_fault, result.address_fault);
					errors++;
				end
				if (expected_lookups[0].address_fault) faults_seen++;
				lookups_checked++;
				void'(expected_lookups.pop_front());
			end
		end
	end

	initial begin
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d lookups pending", cycle_count,
			expected_lookups.size());
		$display("FAIL");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		start <= 1'b0;
		item <= '0;
		trie_cfg.top_point = TOP_POINT_RST;
		trie_cfg.fallback_value = DEFAULT_RST;
		trie_cfg.stage_one_base = STAGE_BASE_RST;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_register_reset();
		test_directed_edges();
		test_random_phases();
		quiesce();
		$display("checked %0d lookups (%0d address faults) among %0d store writes",
			lookups_checked, faults_seen, stores_written);
		$display("%0d register settings over %0d cycles", settings_used, cycle_count);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/cptl_pkg.sv
rtl/cptl_regs.sv
rtl/codepoint_trie_lookup.sv
rtl/cptl_checker.sv
dv/tb_top.sv
